// ===== rtl/core/vram_plane_access_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Plane access controller assertion macros
// Concurrent property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VRAM_PLANE_ACCESS_CONTROLLER_DEFINES_SVH
`define VRAM_PLANE_ACCESS_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define VPAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/vpac_pkg.sv =====
// ----------------------------------------------------------------------------
// Plane access controller package
// Shared types, port decodes and sizes for the plane access controller.
// ----------------------------------------------------------------------------
package vpac_pkg;

  localparam int unsigned PLANE_BYTES = 16384;
  localparam int unsigned PLANE_CNT   = 3;
  localparam int unsigned OFS_W       = $clog2(PLANE_BYTES);
  localparam int unsigned MEM_AW      = OFS_W + 1;
  localparam int unsigned MEM_DEPTH   = 2 * PLANE_BYTES;

  localparam int unsigned CRTC_COUNT  = 18;

  localparam logic [7:0]  CRTC_VTOTAL    = 8'd4;
  localparam logic [7:0]  CRTC_VADJUST   = 8'd5;
  localparam logic [7:0]  CRTC_MAXRASTER = 8'd9;

  localparam logic [15:0] BANK_PORT      = 16'h1fd0;
  localparam logic [15:0] CRTC_PORT_MASK = 16'hff0f;
  localparam logic [15:0] CRTC_IDX_PORT  = 16'h1800;
  localparam logic [15:0] CRTC_DATA_PORT = 16'h1801;

  localparam int unsigned BANK_BIT    = 4;
  localparam int unsigned STROBE_BIT  = 5;
  localparam int unsigned HIRES_LINES = 400;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SIGNAL = 2'd2
  } vpac_op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
  } vpac_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       plane_hit;
    logic       multi_mode;
    logic       hires;
  } vpac_rsp_t;

  typedef struct packed {
    logic       idx_we;
    logic       reg_we;
    logic [7:0] data;
  } vpac_crtc_cmd_t;

endpackage

// ===== rtl/core/vpac_chan_if.sv =====
// ----------------------------------------------------------------------------
// Plane access controller channel
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface vpac_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/core/vpac_plane_ram.sv =====
// ----------------------------------------------------------------------------
// Plane RAM
// One colour plane for both banks, single port, registered read data.
// ----------------------------------------------------------------------------
module vpac_plane_ram
  import vpac_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [MEM_AW-1:0] addr_i,
  input  logic [7:0]        wdata_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [MEM_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/vpac_crtc.sv =====
// ----------------------------------------------------------------------------
// CRTC register bank
// Index register, vertical timing registers and the high-resolution flag.
// ----------------------------------------------------------------------------
module vpac_crtc
  import vpac_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vpac_crtc_cmd_t cmd_i,
  output logic           hires_next_o
);

  logic [7:0]  idx_q, idx_d;
  logic [6:0]  vtot_q, vtot_d;
  logic [4:0]  vadj_q, vadj_d;
  logic [4:0]  rast_q, rast_d;
  logic        hires_q, hires_d;
  logic        reg_hit;
  logic [7:0]  vtot_p1;
  logic [5:0]  rast_p1;
  logic [13:0] lines;

  assign reg_hit = cmd_i.reg_we && (idx_q < 8'(CRTC_COUNT));

  always_comb begin
    idx_d  = cmd_i.idx_we ? cmd_i.data : idx_q;
    vtot_d = vtot_q;
    vadj_d = vadj_q;
    rast_d = rast_q;
    if (reg_hit) begin
      if (idx_q == CRTC_VTOTAL)    vtot_d = cmd_i.data[6:0];
      if (idx_q == CRTC_VADJUST)   vadj_d = cmd_i.data[4:0];
      if (idx_q == CRTC_MAXRASTER) rast_d = cmd_i.data[4:0];
    end
  end

  assign vtot_p1 = {1'b0, vtot_d} + 8'd1;
  assign rast_p1 = {1'b0, rast_d} + 6'd1;
  assign lines   = 14'(vtot_p1) * 14'(rast_p1) + 14'(vadj_d);
  assign hires_d = reg_hit ? (lines > 14'(HIRES_LINES)) : hires_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      vtot_q  <= '0;
      vadj_q  <= '0;
      rast_q  <= '0;
      hires_q <= 1'b1;
    end else begin
      idx_q   <= idx_d;
      vtot_q  <= vtot_d;
      vadj_q  <= vadj_d;
      rast_q  <= rast_d;
      hires_q <= hires_d;
    end
  end

  assign hires_next_o = hires_d;

endmodule

// ===== rtl/core/vram_plane_access_controller.sv =====
// Pipeline: an accepted request beat registers its plane RAM read data and decode flags in
// stage s1, then moves to the output register that drives the response beat. Throughput:
// one request per cycle while the response is not stalled; the decode and plane RAM port
// handle one beat a cycle. Reset: control state clears at once; with ready held low, a clear
// pass over all 32768 addresses zeroes all three plane RAMs in parallel, one address per cycle.
// ----------------------------------------------------------------------------
// Plane access controller
// Decodes bus accesses to three colour planes, the bank port and the CRTC.
// ----------------------------------------------------------------------------
`include "vram_plane_access_controller_defines.svh"

module vram_plane_access_controller
  import vpac_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  vpac_chan_if.sink    req_i,
  vpac_chan_if.source  rsp_o
);

  vpac_req_t      req;
  logic           acc;
  logic [1:0]     region;
  logic [1:0]     own;
  logic           is_rd, is_wr;
  logic           ctrl_wr;
  logic           hit;
  logic           rd_hit;
  logic           hires_next;
  vpac_crtc_cmd_t crtc_cmd;

  logic              clr_busy_q, clr_busy_d;
  logic [MEM_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic              bank_q, bank_d;
  logic              multi_q, multi_d;
  logic              strobe_q, strobe_d;

  logic [PLANE_CNT-1:0] pl_we;
  logic [PLANE_CNT-1:0] ram_we;
  logic [MEM_AW-1:0]    ram_addr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata [PLANE_CNT];

  logic       s1_valid_q, s1_valid_d;
  logic       s1_rd_q, s1_hit_q, s1_multi_q, s1_hires_q;
  logic [1:0] s1_sel_q;
  logic       s1_move;
  logic [7:0] s1_data;

  logic       out_valid_q, out_valid_d;
  vpac_rsp_t  out_q;

  assign req    = req_i.payload;
  assign acc    = req_i.valid && req_i.ready;
  assign region = req.addr[15:14];
  assign own    = region - 2'd1;
  assign is_rd  = (req.op == OP_READ);
  assign is_wr  = (req.op == OP_WRITE);

  assign ctrl_wr = acc && is_wr && (region == 2'd0) && !multi_q;
  assign hit     = (is_rd && (region != 2'd0)) || (is_wr && ((region != 2'd0) || multi_q));
  assign rd_hit  = is_rd && (region != 2'd0);

  assign crtc_cmd.idx_we = ctrl_wr && ((req.addr & CRTC_PORT_MASK) == CRTC_IDX_PORT);
  assign crtc_cmd.reg_we = ctrl_wr && ((req.addr & CRTC_PORT_MASK) == CRTC_DATA_PORT);
  assign crtc_cmd.data   = req.data;

  vpac_crtc u_crtc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (crtc_cmd),
    .hires_next_o (hires_next)
  );

  always_comb begin
    bank_d   = bank_q;
    multi_d  = multi_q;
    strobe_d = strobe_q;
    if (acc) begin
      case (req.op)
        OP_READ: begin
          multi_d = 1'b0;
        end
        OP_WRITE: begin
          if (ctrl_wr && (req.addr == BANK_PORT)) bank_d = req.data[BANK_BIT];
        end
        OP_SIGNAL: begin
          if (strobe_q && !req.data[STROBE_BIT]) multi_d = 1'b1;
          strobe_d = req.data[STROBE_BIT];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < PLANE_CNT; i++) begin
      if (!is_wr) begin
        pl_we[i] = 1'b0;
      end else if (region != 2'd0) begin
        pl_we[i] = multi_q ? (own != 2'(i)) : (own == 2'(i));
      end else begin
        pl_we[i] = multi_q;
      end
    end
  end

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1)) clr_busy_d = 1'b0;
    end
  end

  assign ram_we    = clr_busy_q ? {PLANE_CNT{1'b1}} : (acc ? pl_we : '0);
  assign ram_addr  = clr_busy_q ? clr_cnt_q : {bank_q, req.addr[OFS_W-1:0]};
  assign ram_wdata = clr_busy_q ? 8'h00 : req.data;

  for (genvar g = 0; g < PLANE_CNT; g++) begin : g_plane
    vpac_plane_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .re_i    (acc && rd_hit),
      .addr_i  (ram_addr),
      .wdata_i (ram_wdata),
      .rdata_o (ram_rdata[g])
    );
  end

  assign s1_move     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clr_busy_q && (!s1_valid_q || s1_move);
  assign s1_valid_d  = acc || (s1_valid_q && !s1_move);
  assign out_valid_d = s1_move || (out_valid_q && !rsp_o.ready);

  always_comb begin
    case (s1_sel_q)
      2'd0:    s1_data = ram_rdata[0];
      2'd1:    s1_data = ram_rdata[1];
      2'd2:    s1_data = ram_rdata[2];
      default: s1_data = 8'h00;
    endcase
    if (!s1_rd_q) s1_data = 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      bank_q      <= 1'b0;
      multi_q     <= 1'b0;
      strobe_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_cnt_q   <= clr_cnt_d;
      bank_q      <= bank_d;
      multi_q     <= multi_d;
      strobe_q    <= strobe_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_rd_q    <= rd_hit;
      s1_hit_q   <= hit;
      s1_sel_q   <= own;
      s1_multi_q <= multi_d;
      s1_hires_q <= hires_next;
    end
    if (s1_move) begin
      out_q.read_data  <= s1_data;
      out_q.plane_hit  <= s1_hit_q;
      out_q.multi_mode <= s1_multi_q;
      out_q.hires      <= s1_hires_q;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  `VPAC_ASSERT_NOW(a_no_accept_in_clear, clr_busy_q, !req_i.ready, "request taken during clear pass")
  `VPAC_ASSERT_NOW(a_stall_blocks_input, s1_valid_q && !s1_move, !req_i.ready, "stage overrun")
  `VPAC_ASSERT_NEXT(a_read_clears_multi, acc && is_rd, !multi_q && s1_valid_q, "read kept multi mode")

endmodule
